// ===== design/cpsm_pkg.sv =====
// Package with shared types and constants for the capture period speed meter.
`timescale 1ns / 1ps
package cpsm_pkg;

   localparam int SPEED_FRAC_BITS = 8;
   localparam int STAMP_W = 32;
   localparam int COUNT_W = 32;
   localparam int RATE_W = 24;
   localparam int TIMEOUT_W = 16;
   localparam int AGE_W = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 24;
   localparam int DIV_W = 32;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 8'd1;

   localparam logic [RATE_W-1:0] TICK_RATE_RESET = 24'd1000000;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;

   localparam logic CMD_CAPTURE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [STAMP_W-1:0] capture_time;
   } cpsm_req_type;

   typedef struct packed {
      logic [STAMP_W-1:0] speed_q8;
      logic [STAMP_W-1:0] period_value;
      logic [COUNT_W-1:0] capture_count;
      logic [COUNT_W-1:0] timeout_count;
      logic               timed_out;
   } cpsm_rsp_type;

   typedef struct packed {
      logic               cmd;
      logic [STAMP_W-1:0] period;
   } cpsm_job_type;

   typedef struct packed {
      logic [RATE_W-1:0]    tick_rate_hz;
      logic [TIMEOUT_W-1:0] timeout_ms;
   } cpsm_cfg_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } cpsm_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } cpsm_div_rsp_type;

endpackage

// ===== design/cpsm_front.sv =====
// Front end: accepts items, forms the capture period and queues jobs for the back end.
`timescale 1ns / 1ps
module cpsm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cpsm_pkg::cpsm_req_type req_data,
   output logic                  job_valid,
   input  logic                  job_pop,
   output cpsm_pkg::cpsm_job_type job_data
);
   import cpsm_pkg::*;

   logic [STAMP_W-1:0] prev_stamp_ff, prev_stamp_in;
   cpsm_job_type       slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               push;
   logic               pop;
   cpsm_job_type       job_new;

   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign pop = job_pop && job_valid;
   assign job_valid = (count_ff != 2'd0);
   assign job_data = slot_ff[rd_ptr_ff];

   always_comb begin
      job_new.cmd = req_data.cmd;
      job_new.period = req_data.capture_time - prev_stamp_ff;
      prev_stamp_in = prev_stamp_ff;
      if (push && (req_data.cmd == CMD_CAPTURE)) begin
         prev_stamp_in = req_data.capture_time;
      end
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_stamp_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         prev_stamp_ff <= prev_stamp_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= job_new;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// ===== design/cpsm_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module cpsm_div (
   input  logic                      clock,
   input  logic                      reset,
   input  cpsm_pkg::cpsm_div_req_type div_req,
   output cpsm_pkg::cpsm_div_rsp_type div_rsp
);
   import cpsm_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W:0]       diff;
   logic                 fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff = trial - {1'b0, den_ff};
      fits = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = div_req.dividend;
         den_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a preceding busy cycle");

endmodule

// ===== design/cpsm_back.sv =====
// Back end: keeps the meter state, runs the speed division and holds the result register.
`timescale 1ns / 1ps
module cpsm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  cpsm_pkg::cpsm_cfg_type cfg,
   input  logic                   job_valid,
   output logic                   job_pop,
   input  cpsm_pkg::cpsm_job_type job_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cpsm_pkg::cpsm_rsp_type rsp_data
);
   import cpsm_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [STAMP_W-1:0] last_period_ff, last_period_in;
   logic [AGE_W-1:0]   age_ff, age_in;
   logic [STAMP_W-1:0] speed_ff, speed_in;
   logic [COUNT_W-1:0] captures_ff, captures_in;
   logic [COUNT_W-1:0] timeouts_ff, timeouts_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cpsm_rsp_type       rsp_data_ff;
   logic               load;
   logic               fired;
   logic               out_free;
   logic [AGE_W-1:0]   age_next;
   cpsm_div_req_type   div_req;
   cpsm_div_rsp_type   div_rsp;

   cpsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign age_next = age_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      last_period_in = last_period_ff;
      age_in = age_ff;
      speed_in = speed_ff;
      captures_in = captures_ff;
      timeouts_in = timeouts_ff;
      load = 1'b0;
      fired = 1'b0;
      job_pop = 1'b0;
      div_req.start = 1'b0;
      div_req.dividend = DIV_W'(cfg.tick_rate_hz) << SPEED_FRAC_BITS;
      div_req.divisor = job_data.period;
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid && out_free) begin
               job_pop = 1'b1;
               if (job_data.cmd == CMD_TICK) begin
                  load = 1'b1;
                  age_in = age_next;
                  if (age_next >= cfg.timeout_ms) begin
                     fired = 1'b1;
                     speed_in = '0;
                     timeouts_in = timeouts_ff + 1'b1;
                     age_in = '0;
                  end
               end else begin
                  last_period_in = job_data.period;
                  captures_in = captures_ff + 1'b1;
                  age_in = '0;
                  if (job_data.period == '0) begin
                     load = 1'b1;
                  end else begin
                     div_req.start = 1'b1;
                     state_in = S_DIV;
                  end
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               load = 1'b1;
               speed_in = div_rsp.quotient;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_period_ff <= '0;
         age_ff <= '0;
         speed_ff <= '0;
         captures_ff <= '0;
         timeouts_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_period_ff <= last_period_in;
         age_ff <= age_in;
         speed_ff <= speed_in;
         captures_ff <= captures_in;
         timeouts_ff <= timeouts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff.speed_q8 <= speed_in;
         rsp_data_ff.period_value <= last_period_in;
         rsp_data_ff.capture_count <= captures_in;
         rsp_data_ff.timeout_count <= timeouts_in;
         rsp_data_ff.timed_out <= fired;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_timeout_zero_speed: assert property (@(posedge clock) disable iff (reset)
      (load && fired) |=> (speed_ff == '0 && age_ff == '0 && rsp_data_ff.speed_q8 == '0))
      else $error("timeout did not clear speed and age");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   a_no_load_over_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !load)
      else $error("result register overwritten while stalled");

endmodule

// ===== design/capture_period_speed_meter_top.sv =====
// Top level of the capture period speed meter: configuration registers and front/back hookup.
//
// Items enter on req_valid/req_ready. Each item is a capture event (cmd 0, with a
// 32-bit timer stamp) or a one-millisecond tick (cmd 1); each returns one result on
// rsp_valid/rsp_ready with speed, period, capture and timeout counts and a timeout flag.
// Registers are written through csr_valid/csr_ready with csr_index and csr_wdata:
// index 0 is the timer tick rate in Hz, index 1 the timeout in milliseconds. Writes
// are always accepted and should be made only while the block is idle.
// A tick result is loaded into the result register as the back end pops the tick from
// the queue. A capture with a nonzero period goes through a 32-step restoring divider
// and its quotient is loaded afterwards; the back end takes no new item until then,
// while ticks and zero-period captures sustain one item per cycle when rsp_ready is held high.
// A two-entry queue sits between the front end and the back end, so the block keeps
// accepting items while a result waits; when the receiver stalls the result register
// holds, the queue fills and req_ready then drops.
// Reset clears all meter state and counters and loads tick rate 1000000 Hz and
// timeout 500 ms.
`timescale 1ns / 1ps
module capture_period_speed_meter_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  cpsm_pkg::cpsm_req_type                 req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output cpsm_pkg::cpsm_rsp_type                 rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cpsm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cpsm_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import cpsm_pkg::*;

   cpsm_cfg_type cfg_ff, cfg_in;
   logic         job_valid;
   logic         job_pop;
   cpsm_job_type job_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == CSR_TICK_RATE) begin
            cfg_in.tick_rate_hz = csr_wdata[RATE_W-1:0];
         end else if (csr_index == CSR_TIMEOUT) begin
            cfg_in.timeout_ms = csr_wdata[TIMEOUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_rate_hz <= TICK_RATE_RESET;
         cfg_ff.timeout_ms <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cpsm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job_data  (job_data)
   );

   cpsm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .job_data  (job_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
